// File: rtl/mwc_pkg.sv
// Shared constants, types and helpers for the minimum covering window block.
package mwc_pkg;

    // Sizing of the label count table and the window queue.
    localparam int MAX_LABELS   = 256;
    localparam int WINDOW_DEPTH = 1024;

    // Field widths fixed by the interface.
    localparam int POS_W   = 30;
    localparam int LABEL_W = 8;
    localparam int LEN_W   = 31;
    localparam int NUM_W   = 9;

    // Derived widths.
    localparam int LBL_IDX_W = $clog2(MAX_LABELS);
    localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
    localparam int WIN_W     = LABEL_W + POS_W;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT,
        ST_WIN,
        ST_HCNT,
        ST_SPAN,
        ST_UPD,
        ST_DONE
    } mwc_state_t;

    // Advance a queue index with wraparound at the queue depth.
    function automatic logic [WIN_IDX_W-1:0] next_slot(input logic [WIN_IDX_W-1:0] idx);
        logic [WIN_IDX_W-1:0] res;
        if (idx == WIN_IDX_W'(WINDOW_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + WIN_IDX_W'(1);
        end
        return res;
    endfunction

endpackage

// File: rtl/min_window_cover_all_labels.sv
// Top level: shortest position span covering all labels over a sorted item stream.
//
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_position, s_label, s_last
//  m_        out        m_valid / m_ready      m_min_length, m_found, m_overflow
//  cfg_      in         cfg_wr_en (no wait)    cfg_wr_data (num_labels)
//
// An ignored item (label out of range or queue full) goes from idle straight to done. A
// queued item runs through the count update, then left-end checks that drop entries while
// their label occurs again later (none once the window holds a single entry), then the span
// and best updates; each drop is one window read plus one label count read-modify-write.
// A final item's result waits in the output register; a new item is taken while it
// waits, and only the next final item stalls until it has been taken.
// Reset and the end of each case clear the count table at once through valid bits.
module min_window_cover_all_labels
    import mwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [POS_W-1:0]   s_position,
    input  logic [LABEL_W-1:0] s_label,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEN_W-1:0]   m_min_length,
    output logic               m_found,
    output logic               m_overflow,
    input  logic               cfg_wr_en,
    input  logic [NUM_W-1:0]   cfg_wr_data
);

    mwc_state_t state_reg, state_next;

    logic [NUM_W-1:0]     num_labels_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [LABEL_W-1:0]   lab_reg;
    logic                 last_reg;
    logic [WIN_IDX_W-1:0] head_reg, head_next;
    logic [WIN_IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [NUM_W-1:0]     distinct_reg, distinct_next;
    logic                 covered_reg, covered_next;
    logic [LEN_W-1:0]     best_reg, best_next;
    logic                 ovf_reg, ovf_next;
    logic [LEN_W-1:0]     span_reg, span_next;
    logic [MAX_LABELS-1:0] lbl_valid_reg, lbl_valid_next;

    logic               m_valid_reg, m_valid_next;
    logic [LEN_W-1:0]   m_len_reg;
    logic               m_found_reg;
    logic               m_ovf_reg;

    // Memory ports.
    logic                 cnt_we, cnt_re;
    logic [LBL_IDX_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]     cnt_wdata, cnt_rdata;
    logic                 win_we, win_re;
    logic [WIN_IDX_W-1:0] win_raddr;
    logic [WIN_W-1:0]     win_wdata, win_rdata;

    logic                 in_fire;
    logic                 in_range;
    logic                 q_full;
    logic                 load_result;
    logic [LBL_IDX_W-1:0] lab_idx;
    logic [LBL_IDX_W-1:0] head_lab_idx;
    logic [POS_W-1:0]     head_pos;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W-1:0]     head_cnt;

    // Per-label occurrence counts inside the window.
    mwc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LABELS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Window queue entries: label over position.
    mwc_ram #(.WIDTH(WIN_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (tail_reg),
        .wdata (win_wdata),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    // Input decode.
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign in_range = ({1'b0, s_label} < num_labels_reg) &&
                      (32'(s_label) < MAX_LABELS);
    assign q_full   = (occ_reg >= CNT_W'(WINDOW_DEPTH));

    assign lab_idx      = LBL_IDX_W'(lab_reg);
    assign head_lab_idx = LBL_IDX_W'(win_rdata[POS_W +: LABEL_W]);
    assign head_pos     = win_rdata[POS_W-1:0];
    assign cur_cnt      = lbl_valid_reg[lab_idx] ? cnt_rdata : '0;
    assign head_cnt     = lbl_valid_reg[head_lab_idx] ? cnt_rdata : '0;

    assign load_result = (state_reg == ST_DONE) && last_reg && (!m_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = (in_range && !q_full) ? ST_CNT : ST_DONE;
                end
            end
            ST_CNT:  state_next = ST_WIN;
            ST_WIN:  state_next = (occ_reg > CNT_W'(1)) ? ST_HCNT : ST_SPAN;
            ST_HCNT: state_next = (head_cnt > CNT_W'(1)) ? ST_WIN : ST_SPAN;
            ST_SPAN: state_next = ST_UPD;
            ST_UPD:  state_next = ST_DONE;
            ST_DONE: begin
                if (!last_reg || load_result) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        distinct_next  = distinct_reg;
        covered_next   = covered_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        span_next      = span_reg;
        lbl_valid_next = lbl_valid_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = lab_idx;
        cnt_wdata      = '0;
        cnt_re         = 1'b0;
        cnt_raddr      = LBL_IDX_W'(s_label);
        win_we         = 1'b0;
        win_wdata      = {s_label, s_position};
        win_re         = 1'b0;
        win_raddr      = head_reg;

        case (state_reg)
            ST_IDLE: begin
                // Push at the right end and fetch the label's count.
                if (in_fire && in_range) begin
                    if (q_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        win_we    = 1'b1;
                        tail_next = next_slot(tail_reg);
                        occ_next  = occ_reg + CNT_W'(1);
                        cnt_re    = 1'b1;
                    end
                end
            end
            ST_CNT: begin
                // Bump the count; a first occurrence may complete coverage.
                cnt_we                  = 1'b1;
                cnt_waddr               = lab_idx;
                cnt_wdata               = cur_cnt + CNT_W'(1);
                lbl_valid_next[lab_idx] = 1'b1;
                if (cur_cnt == '0) begin
                    distinct_next = distinct_reg + NUM_W'(1);
                    if (distinct_reg + NUM_W'(1) == num_labels_reg) begin
                        covered_next = 1'b1;
                    end
                end
                win_re    = 1'b1;
                win_raddr = head_reg;
            end
            ST_WIN: begin
                // Fetch the count of the left end's label.
                if (occ_reg > CNT_W'(1)) begin
                    cnt_re    = 1'b1;
                    cnt_raddr = head_lab_idx;
                end
            end
            ST_HCNT: begin
                // Drop the left end while its label occurs again later.
                if (head_cnt > CNT_W'(1)) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = head_lab_idx;
                    cnt_wdata = head_cnt - CNT_W'(1);
                    head_next = next_slot(head_reg);
                    occ_next  = occ_reg - CNT_W'(1);
                    win_re    = 1'b1;
                    win_raddr = next_slot(head_reg);
                end
            end
            ST_SPAN: begin
                // Span from the left end to the new item, at least one.
                if (pos_reg >= head_pos) begin
                    span_next = {1'b0, pos_reg} - {1'b0, head_pos} + LEN_W'(1);
                end else begin
                    span_next = LEN_W'(1);
                end
            end
            ST_UPD: begin
                if (covered_reg && (span_reg < best_reg)) begin
                    best_next = span_reg;
                end
            end
            ST_DONE: begin
                // Clear the whole case once its result is loaded.
                if (load_result) begin
                    head_next      = '0;
                    tail_next      = '0;
                    occ_next       = '0;
                    distinct_next  = '0;
                    covered_next   = 1'b0;
                    best_next      = '1;
                    ovf_next       = 1'b0;
                    lbl_valid_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register handshake.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            num_labels_reg <= NUM_W'(1);
            head_reg       <= '0;
            tail_reg       <= '0;
            occ_reg        <= '0;
            distinct_reg   <= '0;
            covered_reg    <= 1'b0;
            best_reg       <= '1;
            ovf_reg        <= 1'b0;
            lbl_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            distinct_reg  <= distinct_next;
            covered_reg   <= covered_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            lbl_valid_reg <= lbl_valid_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                num_labels_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        span_reg <= span_next;
        if (in_fire) begin
            pos_reg  <= s_position;
            lab_reg  <= s_label;
            last_reg <= s_last;
        end
        if (load_result) begin
            m_len_reg   <= covered_reg ? best_reg : '0;
            m_found_reg <= covered_reg;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_min_length = m_len_reg;
    assign m_found      = m_found_reg;
    assign m_overflow   = m_ovf_reg;

    // The window never holds more entries than the queue depth.
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("window occupancy above queue depth");

    // A queued item leaves at least one entry in the window.
    a_cnt_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CNT |-> occ_reg != '0)
        else $error("count update with empty window");

    // A found result always carries a nonzero span.
    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_found_reg |-> m_len_reg != '0)
        else $error("found result with zero length");

    // A result with nothing found reports length zero.
    a_notfound_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_len_reg == '0)
        else $error("length reported without coverage");

    // Loading a result clears the case state.
    a_case_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> occ_reg == '0 && distinct_reg == '0 && !covered_reg)
        else $error("case state not cleared after result");

endmodule

// File: rtl/mwc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
